FILE: rtl/core/midi_control_map_learn_assert.svh
// Assertion macros for the MIDI learn mapping block
`ifndef MIDI_CONTROL_MAP_LEARN_ASSERT_SVH
`define MIDI_CONTROL_MAP_LEARN_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define MCML_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("midi_control_map_learn: assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low
`define MCML_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("midi_control_map_learn: assertion failed");

`endif

FILE: rtl/core/mcml_pkg.sv
// Shared types, codes and widths for the MIDI learn mapping block
`timescale 1ns / 1ps
package mcml_pkg;
	localparam int SLOTS_DEF = 64;
	localparam int SLOT_W    = 6;
	localparam int NUM_W     = 7;
	localparam int VAL_W     = 7;
	localparam int KIND_W    = 3;
	localparam int MTYPE_W   = 2;
	localparam int BTYPE_W   = 2;
	localparam int EV_W      = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 1;

	localparam logic [BTYPE_W-1:0] BIND_NONE = 2'd0;
	localparam logic [BTYPE_W-1:0] BIND_CC   = 2'd1;
	localparam logic [BTYPE_W-1:0] BIND_NOTE = 2'd2;

	localparam logic [KIND_W-1:0] KIND_MSG    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ARM    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DISARM = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BIND   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	localparam logic [MTYPE_W-1:0] MSG_CC       = 2'd0;
	localparam logic [MTYPE_W-1:0] MSG_NOTE_ON  = 2'd1;
	localparam logic [MTYPE_W-1:0] MSG_NOTE_OFF = 2'd2;

	localparam logic [EV_W-1:0] EV_UPDATE = 2'd0;
	localparam logic [EV_W-1:0] EV_LEARN  = 2'd1;
	localparam logic [EV_W-1:0] EV_ACK    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CC_EN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOTE_EN = 1'b1;

	typedef enum logic [2:0] {
		OP_SCAN_LEARN,
		OP_SCAN,
		OP_ARM,
		OP_DISARM,
		OP_BIND
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [BTYPE_W-1:0] ty;
		logic [NUM_W-1:0]   number;
		logic [VAL_W-1:0]   value;
		logic [SLOT_W-1:0]  slot;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic [BTYPE_W-1:0] kind;
		logic [NUM_W-1:0]   number;
	} slot_ent_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_ACK,
		B_SCAN,
		B_END
	} bstate_t;
endpackage

FILE: rtl/core/mcml_front.sv
// Front end: configuration registers and classification of input items
`timescale 1ns / 1ps
module mcml_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mcml_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcml_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mcml_pkg::KIND_W-1:0]      kind,
	input  logic [mcml_pkg::MTYPE_W-1:0]     message_type,
	input  logic [mcml_pkg::NUM_W-1:0]       number,
	input  logic [mcml_pkg::VAL_W-1:0]       value,
	input  logic [mcml_pkg::SLOT_W-1:0]      slot,
	input  logic [mcml_pkg::BTYPE_W-1:0]     binding_type,
	input  mcml_pkg::qstat_t                 q_stat,
	output logic                             push,
	output mcml_pkg::cmd_t                   push_cmd
);
	import mcml_pkg::*;

	logic               cc_en_q;
	logic               note_en_q;
	logic               keep;
	logic [BTYPE_W-1:0] bty_norm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_en_q   <= 1'b0;
			note_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CC_EN:   cc_en_q   <= cfg_data[0];
				CFG_NOTE_EN: note_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign bty_norm = (binding_type == BIND_CC || binding_type == BIND_NOTE) ?
		binding_type : BIND_NONE;

	always_comb begin
		keep            = 1'b0;
		push_cmd.op     = OP_SCAN;
		push_cmd.ty     = BIND_NONE;
		push_cmd.number = number;
		push_cmd.value  = value;
		push_cmd.slot   = slot;
		unique case (kind)
			KIND_MSG: begin
				unique case (message_type) inside
					MSG_CC: begin
						keep        = cc_en_q;
						push_cmd.op = OP_SCAN_LEARN;
						push_cmd.ty = BIND_CC;
					end
					MSG_NOTE_ON, MSG_NOTE_OFF: begin
						keep        = note_en_q;
						push_cmd.ty = BIND_NOTE;
						// zero velocity note on behaves as note off
						if (message_type == MSG_NOTE_ON && value != '0) begin
							push_cmd.op = OP_SCAN_LEARN;
						end else begin
							push_cmd.op    = OP_SCAN;
							push_cmd.value = '0;
						end
					end
					default: keep = 1'b0;
				endcase
			end
			KIND_ARM: begin
				keep        = 1'b1;
				push_cmd.op = OP_ARM;
			end
			KIND_DISARM: begin
				keep        = 1'b1;
				push_cmd.op = OP_DISARM;
			end
			KIND_BIND: begin
				keep            = 1'b1;
				push_cmd.op     = OP_BIND;
				push_cmd.ty     = bty_norm;
				push_cmd.number = (bty_norm == BIND_NONE) ? '0 : number;
			end
			KIND_CLEAR: begin
				keep            = 1'b1;
				push_cmd.op     = OP_BIND;
				push_cmd.number = '0;
			end
			default: keep = 1'b0;
		endcase
	end

	// ignored items are taken and dropped here
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready && keep;
endmodule

FILE: rtl/core/mcml_queue.sv
// Two-entry command queue between front and back end
`timescale 1ns / 1ps
module mcml_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mcml_pkg::cmd_t   push_cmd,
	input  logic             pop,
	output mcml_pkg::cmd_t   head,
	output mcml_pkg::qstat_t stat
);
	import mcml_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head       = ent_q[rd_q];
	assign stat.full  = cnt_q[1];
	assign stat.empty = (cnt_q == '0);
endmodule

FILE: rtl/core/mcml_back.sv
// Back end: slot table, learn state, slot scan and result register
`timescale 1ns / 1ps
module mcml_back #(
	parameter int SLOTS = mcml_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcml_pkg::cmd_t                head,
	input  mcml_pkg::qstat_t              q_stat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mcml_pkg::EV_W-1:0]     event_res,
	output logic [mcml_pkg::SLOT_W-1:0]   out_slot,
	output logic [mcml_pkg::BTYPE_W-1:0]  out_type,
	output logic [mcml_pkg::VAL_W-1:0]    out_value,
	output logic                          learn_armed,
	output logic                          last
);
	import mcml_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

	slot_ent_t          mem [SLOTS];
	logic [SLOTS-1:0]   vld_q;
	slot_ent_t          rd_q;
	logic               rd_vld_q;

	bstate_t            st_q, st_d;
	logic               learn_q, learn_d;
	logic [SLOT_W-1:0]  target_q, target_d;
	logic [AW-1:0]      idx_q, idx_d;
	logic [AW-1:0]      pend_q, pend_d;
	logic               pend_v_q, pend_v_d;

	logic               out_valid_q;
	logic [EV_W-1:0]    ev_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [BTYPE_W-1:0] type_q;
	logic [VAL_W-1:0]   value_q;
	logic               armed_q;
	logic               last_q;

	logic               we;
	logic [AW-1:0]      wa;
	slot_ent_t          wd;
	logic [AW-1:0]      rd_addr;
	logic               emit;
	logic [EV_W-1:0]    e_ev;
	logic [SLOT_W-1:0]  e_slot;
	logic [BTYPE_W-1:0] e_type;
	logic [VAL_W-1:0]   e_value;
	logic               e_armed;
	logic               e_last;

	logic               can_emit;
	logic               in_rng;
	logic [AW-1:0]      head_addr;
	logic [BTYPE_W-1:0] ent_kind;
	logic [NUM_W-1:0]   ent_num;
	logic               match;
	logic               advance;

	// slot table
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign ent_kind  = rd_vld_q ? rd_q.kind : BIND_NONE;
	assign ent_num   = rd_vld_q ? rd_q.number : '0;
	assign can_emit  = !out_valid_q || out_ready;
	assign in_rng    = ({1'b0, head.slot} < (SLOT_W + 1)'(SLOTS));
	assign head_addr = head.slot[AW-1:0];
	assign match     = (ent_kind == head.ty) && (ent_num == head.number);
	// hold the scan while a found slot waits for a free result register
	assign advance   = !match || !pend_v_q || can_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= B_IDLE;
			learn_q  <= 1'b0;
			target_q <= '0;
			idx_q    <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			learn_q  <= learn_d;
			target_q <= target_d;
			idx_q    <= idx_d;
			pend_q   <= pend_d;
			pend_v_q <= pend_v_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		learn_d  = learn_q;
		target_d = target_q;
		idx_d    = idx_q;
		pend_d   = pend_q;
		pend_v_d = pend_v_q;
		pop      = 1'b0;
		we       = 1'b0;
		wa       = head_addr;
		wd.kind  = head.ty;
		wd.number = head.number;
		rd_addr  = head_addr;
		emit     = 1'b0;
		e_ev     = EV_ACK;
		e_slot   = head.slot;
		e_type   = BIND_NONE;
		e_value  = '0;
		e_armed  = learn_q;
		e_last   = 1'b1;
		unique case (st_q)
			B_IDLE: begin
				if (!q_stat.empty) begin
					unique case (head.op) inside
						OP_ARM: begin
							if (in_rng) begin
								learn_d  = 1'b1;
								target_d = head.slot;
							end
							st_d = B_ACK;
						end
						OP_DISARM: begin
							if (head.slot == target_q) begin
								learn_d = 1'b0;
							end
							st_d = B_ACK;
						end
						OP_BIND: begin
							if (can_emit) begin
								we     = in_rng;
								emit   = 1'b1;
								e_type = in_rng ? head.ty : BIND_NONE;
								pop    = 1'b1;
							end
						end
						OP_SCAN_LEARN, OP_SCAN: begin
							if (head.op == OP_SCAN_LEARN && learn_q && head.value != '0) begin
								if (can_emit) begin
									we      = 1'b1;
									wa      = target_q[AW-1:0];
									learn_d = 1'b0;
									emit    = 1'b1;
									e_ev    = EV_LEARN;
									e_slot  = target_q;
									e_type  = head.ty;
									e_armed = 1'b0;
									pop     = 1'b1;
								end
							end else begin
								rd_addr  = '0;
								idx_d    = '0;
								pend_v_d = 1'b0;
								st_d     = B_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			B_ACK: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_type = in_rng ? ent_kind : BIND_NONE;
					pop    = 1'b1;
					st_d   = B_IDLE;
				end
			end
			B_SCAN: begin
				rd_addr = (advance && idx_q != LAST_IDX) ? idx_q + 1'b1 : idx_q;
				e_ev    = EV_UPDATE;
				e_slot  = SLOT_W'(pend_q);
				e_type  = head.ty;
				e_value = head.value;
				e_last  = 1'b0;
				if (advance) begin
					if (match) begin
						// the earlier match is now known not to be the last one
						emit     = pend_v_q;
						pend_d   = idx_q;
						pend_v_d = 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						st_d = B_END;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			B_END: begin
				e_ev    = EV_UPDATE;
				e_slot  = SLOT_W'(pend_q);
				e_type  = head.ty;
				e_value = head.value;
				if (!pend_v_q) begin
					pop  = 1'b1;
					st_d = B_IDLE;
				end else if (can_emit) begin
					emit = 1'b1;
					pop  = 1'b1;
					st_d = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ev_q    <= e_ev;
			slot_q  <= e_slot;
			type_q  <= e_type;
			value_q <= e_value;
			armed_q <= e_armed;
			last_q  <= e_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = ev_q;
	assign out_slot    = slot_q;
	assign out_type    = type_q;
	assign out_value   = value_q;
	assign learn_armed = armed_q;
	assign last        = last_q;
endmodule

FILE: rtl/core/midi_control_map_learn.sv
// Top level of the MIDI learn controller mapping block
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) takes one item per transfer: a MIDI
//   message (CC, note on, note off) or a control item (arm, disarm, bind,
//   clear). Output channel (out_valid/out_ready) gives result items; the
//   result field last marks the final result caused by one input item.
//   cfg_we/cfg_index/cfg_data write cc_enable (index 0) and note_enable
//   (index 1); write them only while the block is idle.
// Timing:
//   Bind, clear and learning messages are handled in the back end's idle state;
//   arm and disarm also pass the ack state (one slot table read). A tracked
//   message that does not learn scans the table one slot a cycle, set by the
//   single read port of the slot table, and pauses while a match waits for the
//   result register. Each result passes the queue and the result register.
//   A two-entry queue lets the input side keep taking items while results wait.
// Reset clears the slot table (all slots unbound), learn state and enables.
// When the receiver stalls, the result register holds and the scan pauses;
// the input side stalls once the queue is full.
module midi_control_map_learn #(
	parameter int SLOTS = mcml_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mcml_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcml_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mcml_pkg::KIND_W-1:0]      kind,
	input  logic [mcml_pkg::MTYPE_W-1:0]     message_type,
	input  logic [mcml_pkg::NUM_W-1:0]       number,
	input  logic [mcml_pkg::VAL_W-1:0]       value,
	input  logic [mcml_pkg::SLOT_W-1:0]      slot,
	input  logic [mcml_pkg::BTYPE_W-1:0]     binding_type,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mcml_pkg::EV_W-1:0]        event_res,
	output logic [mcml_pkg::SLOT_W-1:0]      out_slot,
	output logic [mcml_pkg::BTYPE_W-1:0]     out_type,
	output logic [mcml_pkg::VAL_W-1:0]       out_value,
	output logic                             learn_armed,
	output logic                             last
);
	import mcml_pkg::*;

`include "midi_control_map_learn_assert.svh"

	logic   push;
	logic   pop;
	cmd_t   push_cmd;
	cmd_t   head;
	qstat_t q_stat;

	mcml_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.message_type (message_type),
		.number       (number),
		.value        (value),
		.slot         (slot),
		.binding_type (binding_type),
		.q_stat       (q_stat),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	mcml_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	mcml_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_res   (event_res),
		.out_slot    (out_slot),
		.out_type    (out_type),
		.out_value   (out_value),
		.learn_armed (learn_armed),
		.last        (last)
	);

	`MCML_ASSERT_NOW(a_only_updates_not_last, out_valid && !last, event_res == EV_UPDATE)
	`MCML_ASSERT_NOW(a_learn_disarms, out_valid && event_res == EV_LEARN, !learn_armed)
	`MCML_ASSERT_NOW(a_ctrl_value_zero, out_valid && event_res != EV_UPDATE, out_value == '0)
	`MCML_ASSERT_NEXT(a_push_fills_queue, push && !pop, !q_stat.empty)
endmodule

FILE: tb/sv/midi_control_map_learn_test.sv
// Self-checking testbench for the MIDI learn controller mapping block
`timescale 1ns / 1ps
module midi_control_map_learn_test;
	import mcml_pkg::*;

	localparam logic [MTYPE_W-1:0] MSG_UNKNOWN    = 2'd3;
	localparam logic [BTYPE_W-1:0] BIND_BAD       = 2'd3;
	localparam logic [KIND_W-1:0]  KIND_RSVD_LOW  = 3'd5;
	localparam logic [KIND_W-1:0]  KIND_RSVD_HIGH = 3'd7;
	// covers two silent scans still queued after the last transfer
	localparam int TAIL_CYCLES = 2 * (SLOTS_DEF + 2) + 16;
	localparam int HOLD_CYCLES = 400;
	localparam int PRINT_CAP   = 200;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [MTYPE_W-1:0] mtype;
		logic [NUM_W-1:0]   number;
		logic [VAL_W-1:0]   value;
		logic [SLOT_W-1:0]  slot;
		logic [BTYPE_W-1:0] btype;
	} midi_item_t;

	typedef struct packed {
		logic [EV_W-1:0]    ev;
		logic [SLOT_W-1:0]  slot;
		logic [BTYPE_W-1:0] ty;
		logic [VAL_W-1:0]   val;
		logic               armed;
		logic               last_flag;
	} map_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [KIND_W-1:0]    kind = '0;
	logic [MTYPE_W-1:0]   message_type = '0;
	logic [NUM_W-1:0]     number = '0;
	logic [VAL_W-1:0]     value = '0;
	logic [SLOT_W-1:0]    slot = '0;
	logic [BTYPE_W-1:0]   binding_type = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [EV_W-1:0]      event_res;
	logic [SLOT_W-1:0]    out_slot;
	logic [BTYPE_W-1:0]   out_type;
	logic [VAL_W-1:0]     out_value;
	logic                 learn_armed;
	logic                 last;

	midi_control_map_learn u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.message_type (message_type),
		.number       (number),
		.value        (value),
		.slot         (slot),
		.binding_type (binding_type),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.out_slot     (out_slot),
		.out_type     (out_type),
		.out_value    (out_value),
		.learn_armed  (learn_armed),
		.last         (last)
	);

	always #1 clk = ~clk;

	// Mapping state mirrored by the predictor
	logic [BTYPE_W-1:0] map_kind [SLOTS_DEF];
	logic [NUM_W-1:0]   map_num  [SLOTS_DEF];
	logic               learn_on_m = 1'b0;
	logic [SLOT_W-1:0]  learn_slot_m = '0;
	logic               cc_track = 1'b0;
	logic               note_track = 1'b0;

	midi_item_t  outgoing_items[$];
	map_result_t due_results[$];

	int          sender_idle_pct = 0;
	int          rcv_stall_pct = 0;
	int          hold_epoch = 0;
	logic        in_taken = 1'b0;
	int          mismatch_count = 0;
	int          results_checked = 0;
	int          items_in = 0;
	int          largest_burst = 0;
	logic [SLOT_W-1:0] gen_last_arm = '0;

	initial begin
		for (int i = 0; i < SLOTS_DEF; i++) begin
			map_kind[i] = BIND_NONE;
			map_num[i]  = '0;
		end
	end

	function automatic midi_item_t mk(input logic [KIND_W-1:0] k, input logic [MTYPE_W-1:0] m,
			input logic [NUM_W-1:0] n, input logic [VAL_W-1:0] v,
			input logic [SLOT_W-1:0] s, input logic [BTYPE_W-1:0] b);
		midi_item_t it;
		it = '{k, m, n, v, s, b};
		return it;
	endfunction

	// Append one item to the sender's pending list
	function automatic void offer(input midi_item_t it);
		outgoing_items.insert(outgoing_items.size(), it);
	endfunction

	function automatic void push_result(input logic [EV_W-1:0] ev, input logic [SLOT_W-1:0] s,
			input logic [BTYPE_W-1:0] ty, input logic [VAL_W-1:0] v, input logic fin);
		map_result_t r;
		r = '{ev, s, ty, v, learn_on_m, fin};
		due_results.insert(due_results.size(), r);
	endfunction

	function automatic void bind_entry(input logic [SLOT_W-1:0] s, input logic [BTYPE_W-1:0] ty,
			input logic [NUM_W-1:0] n);
		if (int'(s) >= SLOTS_DEF)
			return;
		if (ty == BIND_CC || ty == BIND_NOTE) begin
			map_kind[s] = ty;
			map_num[s]  = n;
		end else begin
			map_kind[s] = BIND_NONE;
			map_num[s]  = '0;
		end
	endfunction

	function automatic logic [BTYPE_W-1:0] kind_of(input logic [SLOT_W-1:0] s);
		return (int'(s) < SLOTS_DEF) ? map_kind[s] : BIND_NONE;
	endfunction

	function automatic int scan_map(input logic [BTYPE_W-1:0] ty, input logic [NUM_W-1:0] n,
			input logic [VAL_W-1:0] v);
		int final_hit;
		int hits;
		final_hit = -1;
		hits = 0;
		for (int i = 0; i < SLOTS_DEF; i++)
			if (map_kind[i] == ty && map_num[i] == n)
				final_hit = i;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			if (map_kind[i] == ty && map_num[i] == n) begin
				push_result(EV_UPDATE, SLOT_W'(i), ty, v, i == final_hit);
				hits++;
			end
		end
		return hits;
	endfunction

	function automatic int learn_or_scan(input logic [BTYPE_W-1:0] ty, input logic [NUM_W-1:0] n,
			input logic [VAL_W-1:0] v);
		if (learn_on_m && v != '0) begin
			bind_entry(learn_slot_m, ty, n);
			learn_on_m = 1'b0;
			push_result(EV_LEARN, learn_slot_m, kind_of(learn_slot_m), '0, 1'b1);
			return 1;
		end
		return scan_map(ty, n, v);
	endfunction

	// Apply one transferred item to the mirror, queue what it should produce
	function automatic int map_apply(input midi_item_t it);
		case (it.kind)
			KIND_MSG: begin
				if (it.mtype == MSG_CC)
					return cc_track ? learn_or_scan(BIND_CC, it.number, it.value) : 0;
				if (it.mtype == MSG_NOTE_ON || it.mtype == MSG_NOTE_OFF) begin
					if (!note_track)
						return 0;
					if (it.mtype == MSG_NOTE_ON && it.value != '0)
						return learn_or_scan(BIND_NOTE, it.number, it.value);
					return scan_map(BIND_NOTE, it.number, '0);
				end
				return 0;
			end
			KIND_ARM: begin
				if (int'(it.slot) < SLOTS_DEF) begin
					learn_on_m   = 1'b1;
					learn_slot_m = it.slot;
				end
			end
			KIND_DISARM: if (it.slot == learn_slot_m) learn_on_m = 1'b0;
			KIND_BIND:   bind_entry(it.slot, it.btype, it.number);
			KIND_CLEAR:  bind_entry(it.slot, BIND_NONE, '0);
			default:     return 0;
		endcase
		push_result(EV_ACK, it.slot, kind_of(it.slot), '0, 1'b1);
		return 1;
	endfunction

	function automatic logic [NUM_W-1:0] pick_number();
		// a small pool makes bindings collide so messages hit several slots
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return NUM_W'(42);
			3: return NUM_W'(85);
			4: return NUM_W'(85);
			5: return NUM_W'(42);
			default: return NUM_W'($urandom);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0, 1: return '0;
			2: return '1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic midi_item_t random_item();
		logic [$bits(midi_item_t)-1:0] raw;
		midi_item_t it;
		int r;
		raw = $bits(midi_item_t)'($urandom);
		it  = raw;
		r   = $urandom_range(99);
		if (r < 45) begin
			it.kind   = KIND_MSG;
			it.mtype  = ($urandom_range(19) == 0) ? MSG_UNKNOWN : MTYPE_W'($urandom_range(2));
			it.number = pick_number();
			it.value  = pick_value();
		end else if (r < 65) begin
			it.kind   = KIND_BIND;
			it.number = pick_number();
			if ($urandom_range(9) < 8)
				it.btype = $urandom_range(1) ? BIND_CC : BIND_NOTE;
			else
				it.btype = $urandom_range(1) ? BIND_NONE : BIND_BAD;
		end else if (r < 72) begin
			it.kind = KIND_CLEAR;
		end else if (r < 82) begin
			it.kind      = KIND_ARM;
			gen_last_arm = it.slot;
		end else if (r < 88) begin
			it.kind = KIND_DISARM;
			if ($urandom_range(1))
				it.slot = gen_last_arm;
		end
		// remaining share keeps the raw noise, reserved kinds included
		return it;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want_v);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at result %0d: %s got %0d, wanted %0d",
				results_checked, what, got, want_v);
	endtask

	// Sender: hold the payload until transferred, then maybe idle
	always @(negedge clk) begin : drive_in
		midi_item_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (outgoing_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				nxt = outgoing_items.pop_front();
				in_valid     <= 1'b1;
				kind         <= nxt.kind;
				message_type <= nxt.mtype;
				number       <= nxt.number;
				value        <= nxt.value;
				slot         <= nxt.slot;
				binding_type <= nxt.btype;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin : drive_out
		int hold_left;
		int seen_epoch;
		if (hold_epoch != seen_epoch) begin
			seen_epoch = hold_epoch;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin : watch
		map_result_t want;
		int n;
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			n = map_apply(mk(kind, message_type, number, value, slot, binding_type));
			items_in++;
			if (n > largest_burst)
				largest_burst = n;
		end
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing due, slot", out_slot, -1);
			end else begin
				want = due_results.pop_front();
				if (event_res !== want.ev)
					report_mismatch("event_res", event_res, want.ev);
				if (out_slot !== want.slot)
					report_mismatch("out_slot", out_slot, want.slot);
				if (out_type !== want.ty)
					report_mismatch("out_type", out_type, want.ty);
				if (out_value !== want.val)
					report_mismatch("out_value", out_value, want.val);
				if (learn_armed !== want.armed)
					report_mismatch("learn_armed", learn_armed, want.armed);
				if (last !== want.last_flag)
					report_mismatch("last", last, want.last_flag);
			end
			results_checked++;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		if (idx == CFG_CC_EN)
			cc_track = d;
		else
			note_track = d;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every item is transferred and every result is back, then let scans finish
	task automatic wait_drained();
		while (outgoing_items.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic push_random(input int count);
		repeat (count) offer(random_item());
	endtask

	initial begin : run
		int cc_set[4]    = '{1, 1, 0, 1};
		int note_set[4]  = '{1, 0, 1, 1};
		int idle_set[4]  = '{0, 71, 0, 16};
		int stall_set[4] = '{0, 0, 71, 16};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// tracking off: binds land, messages are dropped
		write_reg(CFG_CC_EN, 1'b0);
		write_reg(CFG_NOTE_EN, 1'b0);
		offer(mk(KIND_BIND, MSG_CC, 0, 0, 0, BIND_CC));
		offer(mk(KIND_BIND, MSG_CC, 127, 0, 63, BIND_NOTE));
		offer(mk(KIND_MSG, MSG_CC, 0, 127, 0, BIND_NONE));
		offer(mk(KIND_MSG, MSG_NOTE_ON, 127, 127, 0, BIND_NONE));
		wait_drained();

		write_reg(CFG_CC_EN, 1'b1);
		write_reg(CFG_NOTE_EN, 1'b1);
		offer(mk(KIND_MSG, MSG_CC, 0, 127, 0, BIND_NONE));
		// zero-velocity note on behaves as note off
		offer(mk(KIND_MSG, MSG_NOTE_ON, 127, 0, 0, BIND_NONE));
		offer(mk(KIND_MSG, MSG_NOTE_OFF, 127, 127, 0, BIND_NONE));
		offer(mk(KIND_MSG, MSG_UNKNOWN, 0, 5, 0, BIND_NONE));
		offer(mk(KIND_RSVD_LOW, MSG_CC, 0, 1, 3, BIND_CC));
		offer(mk(KIND_RSVD_HIGH, MSG_UNKNOWN, 127, 127, 63, BIND_BAD));
		offer(mk(KIND_BIND, MSG_CC, 99, 0, 10, BIND_BAD));
		offer(mk(KIND_BIND, MSG_CC, 127, 0, 11, BIND_NONE));
		offer(mk(KIND_MSG, MSG_CC, 5, 9, 0, BIND_NONE));
		offer(mk(KIND_ARM, MSG_CC, 0, 0, 63, BIND_NONE));
		offer(mk(KIND_DISARM, MSG_CC, 0, 0, 62, BIND_NONE));
		// armed: note off and zero-value CC must not learn
		offer(mk(KIND_MSG, MSG_NOTE_OFF, 1, 100, 0, BIND_NONE));
		offer(mk(KIND_MSG, MSG_CC, 0, 0, 0, BIND_NONE));
		offer(mk(KIND_MSG, MSG_NOTE_ON, 42, 64, 0, BIND_NONE));
		offer(mk(KIND_ARM, MSG_CC, 0, 0, 0, BIND_NONE));
		offer(mk(KIND_DISARM, MSG_CC, 0, 0, 0, BIND_NONE));
		offer(mk(KIND_ARM, MSG_CC, 0, 0, 1, BIND_NONE));
		offer(mk(KIND_MSG, MSG_CC, 127, 1, 0, BIND_NONE));
		offer(mk(KIND_CLEAR, MSG_CC, 0, 0, 63, BIND_NONE));
		offer(mk(KIND_BIND, MSG_CC, 5, 0, 1, BIND_NOTE));
		offer(mk(KIND_MSG, MSG_NOTE_ON, 5, 127, 0, BIND_NONE));
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			write_reg(CFG_CC_EN, CFG_DAT_W'(cc_set[p]));
			write_reg(CFG_NOTE_EN, CFG_DAT_W'(note_set[p]));
			sender_idle_pct = idle_set[p];
			rcv_stall_pct   = stall_set[p];
			push_random(45);
			// pause the sender until everything due has come back
			wait_drained();
			push_random(45);
			wait_drained();
		end

		// every slot on one controller, receiver held off while binds pile up
		sender_idle_pct = 0;
		rcv_stall_pct   = 71;
		hold_epoch++;
		offer(mk(KIND_DISARM, MSG_CC, 0, 0, gen_last_arm, BIND_NONE));
		for (int i = 0; i < SLOTS_DEF; i++)
			offer(mk(KIND_BIND, MSG_CC, 127, 0, SLOT_W'(i), BIND_CC));
		offer(mk(KIND_MSG, MSG_CC, 127, 100, 0, BIND_NONE));
		offer(mk(KIND_MSG, MSG_CC, 127, 0, 0, BIND_NONE));
		wait_drained();

		$display("Run covered %0d input transfers and %0d checked results over all four enable settings,",
			items_in, results_checked);
		$display("with up to %0d results from a single message and %0d mismatches.",
			largest_burst, mismatch_count);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("timeout: %0d results still due", due_results.size());
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
